### rtl/core/mqttdf_pkg.sv
// Shared types and constants for the MQTT inbound packet deframer.
`default_nettype none
package mqttdf_pkg;

    localparam int BUF_W = 21;
    localparam int TMO_W = 26;
    localparam int LEN_W = 28;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [BUF_W-1:0] BUFFER_SIZE_RESET = 21'd256;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 26'd5000;

    // register index, taken from paddr[2]
    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_LENGTH = 3'd1;
    localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
    localparam logic [2:0] ROLE_TOPIC = 3'd3;
    localparam logic [2:0] ROLE_PACKET_ID = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
    localparam logic [2:0] ROLE_OTHER = 3'd6;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LEN_BYTES = 2'd1;
    localparam logic [1:0] ERR_BUFFER = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT = 2'd3;

    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam int HEADER_RESERVE = 5;
    localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [2:0]       byte_role;
        logic [3:0]       packet_type;
        logic [3:0]       packet_flags;
        logic [1:0]       qos_level;
        logic [LEN_W-1:0] remaining_length;
        logic             packet_end;
        logic [1:0]       error_code;
    } result_t;

    typedef struct packed {
        logic [BUF_W-1:0] buffer_size;
        logic [TMO_W-1:0] timeout_ticks;
    } cfg_t;

endpackage
`default_nettype wire

### rtl/core/mqttdf_cfg.sv
// APB configuration registers of the deframer.
`default_nettype none
module mqttdf_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mqttdf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mqttdf_pkg::DATA_W-1:0]  pwdata,
    output logic      [mqttdf_pkg::DATA_W-1:0]  prdata,
    output logic                                pready,
    output mqttdf_pkg::cfg_t                    cfg
);

    logic [mqttdf_pkg::BUF_W-1:0] buffer_size_reg;
    logic [mqttdf_pkg::TMO_W-1:0] timeout_reg;
    logic                         wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= mqttdf_pkg::BUFFER_SIZE_RESET;
            timeout_reg     <= mqttdf_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == mqttdf_pkg::REG_BUFFER_SIZE)
                buffer_size_reg <= pwdata[mqttdf_pkg::BUF_W-1:0];
            else
                timeout_reg <= pwdata[mqttdf_pkg::TMO_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == mqttdf_pkg::REG_TIMEOUT)
            prdata = {{(mqttdf_pkg::DATA_W-mqttdf_pkg::TMO_W){1'b0}}, timeout_reg};
        else
            prdata = {{(mqttdf_pkg::DATA_W-mqttdf_pkg::BUF_W){1'b0}}, buffer_size_reg};
    end

    assign cfg.buffer_size   = buffer_size_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule
`default_nettype wire

### rtl/core/mqttdf_parse.sv
// Deframer state and combinational next-state / result logic.
`default_nettype none
module mqttdf_parse
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic             req_type,
    input  wire logic [7:0]       in_byte,
    input  wire mqttdf_pkg::cfg_t cfg,
    output logic                  has_result,
    output mqttdf_pkg::result_t   result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam int LW = mqttdf_pkg::LEN_W;

    logic [1:0]                   phase_reg, phase_next;
    logic [7:0]                   header_reg, header_next;
    logic [LW-1:0]                accum_reg, accum_next;
    logic [2:0]                   len_cnt_reg, len_cnt_next;
    logic [LW-1:0]                body_cnt_reg, body_cnt_next;
    logic [15:0]                  topic_reg, topic_next;
    logic [mqttdf_pkg::TMO_W-1:0] tick_reg, tick_next;

    logic [mqttdf_pkg::TMO_W-1:0] tick_inc;
    logic [LW-1:0]                len_group;
    logic [LW-1:0]                accum_upd;
    logic                         over_buffer;
    logic [LW-1:0]                body_inc;
    logic [15:0]                  topic_upd;
    logic [LW:0]                  topic_lim;
    logic [LW:0]                  id_lim;
    logic [2:0]                   body_role;
    logic [7:0]                   res_byte;
    logic [2:0]                   res_role;
    logic                         res_end;
    logic [1:0]                   res_err;

    // length group placed at bit 7*count
    always_comb
    begin
        case (len_cnt_reg[1:0])
            2'd0:    len_group = {21'd0, in_byte[6:0]};
            2'd1:    len_group = {14'd0, in_byte[6:0], 7'd0};
            2'd2:    len_group = {7'd0, in_byte[6:0], 14'd0};
            default: len_group = {in_byte[6:0], 21'd0};
        endcase
    end

    assign accum_upd   = accum_reg | len_group;
    assign over_buffer = ({1'b0, accum_upd} + (LW+1)'(mqttdf_pkg::HEADER_RESERVE))
                         > (LW+1)'(cfg.buffer_size);
    assign tick_inc    = tick_reg + 1'b1;
    assign body_inc    = body_cnt_reg + 1'b1;

    always_comb
    begin
        if (body_cnt_reg == '0)
            topic_upd = {in_byte, 8'h00};
        else if (body_cnt_reg == LW'(1))
            topic_upd = {topic_reg[15:8], in_byte};
        else
            topic_upd = topic_reg;
    end

    assign topic_lim = (LW+1)'(topic_upd) + (LW+1)'(2);
    assign id_lim    = (LW+1)'(topic_upd) + (LW+1)'(4);

    always_comb
    begin
        if (header_reg[7:4] != mqttdf_pkg::TYPE_PUBLISH)
            body_role = mqttdf_pkg::ROLE_OTHER;
        else if (body_cnt_reg < LW'(2))
            body_role = mqttdf_pkg::ROLE_TOPIC_LEN;
        else if ({1'b0, body_cnt_reg} < topic_lim)
            body_role = mqttdf_pkg::ROLE_TOPIC;
        else if ((header_reg[2:1] != 2'd0) && ({1'b0, body_cnt_reg} < id_lim))
            body_role = mqttdf_pkg::ROLE_PACKET_ID;
        else
            body_role = mqttdf_pkg::ROLE_PAYLOAD;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        header_next   = header_reg;
        accum_next    = accum_reg;
        len_cnt_next  = len_cnt_reg;
        body_cnt_next = body_cnt_reg;
        topic_next    = topic_reg;
        tick_next     = tick_reg;
        has_result    = 1'b0;
        res_byte      = in_byte;
        res_role      = mqttdf_pkg::ROLE_LENGTH;
        res_end       = 1'b0;
        res_err       = mqttdf_pkg::ERR_NONE;

        if (req_type == mqttdf_pkg::REQ_TICK)
        begin
            res_byte = 8'd0;
            res_role = mqttdf_pkg::ROLE_HEADER;
            if (phase_reg != PH_IDLE)
            begin
                if (tick_inc >= cfg.timeout_ticks)
                begin
                    has_result = 1'b1;
                    res_err    = mqttdf_pkg::ERR_TIMEOUT;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_inc;
            end
        end
        else
        begin
            tick_next  = '0;
            has_result = 1'b1;
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (len_cnt_reg >= mqttdf_pkg::MAX_LEN_BYTES)
                    begin
                        res_err    = mqttdf_pkg::ERR_LEN_BYTES;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        accum_next   = accum_upd;
                        len_cnt_next = len_cnt_reg + 1'b1;
                        if (in_byte[7])
                        begin
                            // more length bytes follow
                        end
                        else if (over_buffer)
                        begin
                            res_err    = mqttdf_pkg::ERR_BUFFER;
                            phase_next = PH_IDLE;
                        end
                        else if (accum_upd == '0)
                        begin
                            res_end    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next    = PH_BODY;
                            body_cnt_next = '0;
                            topic_next    = '0;
                        end
                    end
                end
                PH_BODY:
                begin
                    topic_next    = topic_upd;
                    body_cnt_next = body_inc;
                    res_role      = body_role;
                    res_end       = (body_inc >= accum_reg);
                    if (res_end)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    // idle (or unused code): header byte
                    header_next   = in_byte;
                    accum_next    = '0;
                    len_cnt_next  = '0;
                    body_cnt_next = '0;
                    topic_next    = '0;
                    phase_next    = PH_LEN;
                    res_role      = mqttdf_pkg::ROLE_HEADER;
                end
            endcase
        end
    end

    // result fields reflect the state after this word
    assign result.out_byte         = res_byte;
    assign result.byte_role        = res_role;
    assign result.packet_type      = header_next[7:4];
    assign result.packet_flags     = header_next[3:0];
    assign result.qos_level        = header_next[2:1];
    assign result.remaining_length = accum_next;
    assign result.packet_end       = res_end;
    assign result.error_code       = res_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            header_reg   <= '0;
            accum_reg    <= '0;
            len_cnt_reg  <= '0;
            body_cnt_reg <= '0;
            topic_reg    <= '0;
            tick_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            header_reg   <= header_next;
            accum_reg    <= accum_next;
            len_cnt_reg  <= len_cnt_next;
            body_cnt_reg <= body_cnt_next;
            topic_reg    <= topic_next;
            tick_reg     <= tick_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mqtt_inbound_packet_deframer_unit.sv
// Top level of the MQTT inbound packet deframer: input register, parser, result register.
// Path: input register, parser, result register; a held word waits while the result register is full.
// Throughput: one word (byte or tick) per cycle, sustained, whenever out_ready holds high.
// The input register refills in the same cycle it drains; the result register is
// reloaded while its old word is taken, so neither side waits on the other.
// Reset (rst_n low, async): parser back to idle, counters and header cleared,
// buffer_size = 256, timeout_ticks = 5000, both valid flags low.
`default_nettype none
module mqtt_inbound_packet_deframer_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // input words
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                req_type,
    input  wire logic [7:0]                          in_byte,

    // result words
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [7:0]                               out_byte,
    output logic [2:0]                               byte_role,
    output logic [3:0]                               packet_type,
    output logic [3:0]                               packet_flags,
    output logic [1:0]                               qos_level,
    output logic [mqttdf_pkg::LEN_W-1:0]             remaining_length,
    output logic                                     packet_end,
    output logic [1:0]                               error_code,

    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mqttdf_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [mqttdf_pkg::DATA_W-1:0]       pwdata,
    output logic      [mqttdf_pkg::DATA_W-1:0]       prdata,
    output logic                                     pready
);

    mqttdf_pkg::cfg_t    cfg;
    mqttdf_pkg::result_t result;
    mqttdf_pkg::result_t res_reg;

    logic       in_valid_reg, in_valid_next;
    logic       req_type_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       has_result;
    logic       fire;
    logic       out_free;

    mqttdf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held word is processed once the result register can take its result.
    // Ticks that give no result still wait for that slot; it costs nothing at full rate.
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;

    mqttdf_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req_type   (req_type_reg),
        .in_byte    (in_byte_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire && has_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            in_byte_reg  <= in_byte;
        end
        if (fire && has_result)
            res_reg <= result;
    end

    assign out_valid        = out_valid_reg;
    assign out_byte         = res_reg.out_byte;
    assign byte_role        = res_reg.byte_role;
    assign packet_type      = res_reg.packet_type;
    assign packet_flags     = res_reg.packet_flags;
    assign qos_level        = res_reg.qos_level;
    assign remaining_length = res_reg.remaining_length;
    assign packet_end       = res_reg.packet_end;
    assign error_code       = res_reg.error_code;

endmodule
`default_nettype wire
